@@ rtl/tlpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpr_pkg
// Types, constants and helper functions for the telemetry line parser/router.
// ----------------------------------------------------------------------------
package tlpr_pkg;

    localparam int DEF_NUM_ADDRESSES = 10;
    localparam int DEF_MAX_LINE      = 32;
    localparam int FRAC_DIGITS       = 3;

    localparam int FC_W  = 3;
    localparam int POW_W = 14;

    localparam logic signed [31:0] NO_VALUE  = -32'sd9900;
    localparam logic [31:0]        MAG_LIMIT = 32'h7FFF_FFFF;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_CMD   = 3'd1,
        PH_BLANK = 3'd2,
        PH_INT   = 3'd3,
        PH_FRAC  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] qty;
    } qty_dec_t;

    function automatic qty_dec_t quantity_of(input logic [7:0] c);
        qty_dec_t d;
        d.ok  = 1'b1;
        d.qty = 2'd0;
        case (c)
            8'h49, 8'h69: d.qty = 2'd0;
            8'h52, 8'h72: d.qty = 2'd1;
            8'h46, 8'h66: d.qty = 2'd2;
            8'h50, 8'h70: d.qty = 2'd3;
            default:      d.ok  = 1'b0;
        endcase
        return d;
    endfunction

    // acc * 10 + digit, saturated at MAG_LIMIT
    function automatic logic [31:0] sat_mac(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
        return (v > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : v[31:0];
    endfunction

    function automatic logic [POW_W-1:0] pow_ten(input logic [FC_W-1:0] s);
        logic [POW_W-1:0] p;
        case (s)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            default: p = 14'd10000;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tlpr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/telemetry_line_parser_router.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_line_parser_router
// Parses LF-terminated telemetry lines into a value/time store, answers queries.
// ----------------------------------------------------------------------------
// One beat per clock is taken while item_stall is low: a received byte, a
// millisecond tick or a query. A beat passes an input register, a parse/read
// stage and the result register to reach the result channel, with no gaps for
// back-to-back beats unless a result stalls. The store sits in one RAM
// with a registered read port; a line write and a read of the same entry in
// the next beat are forwarded. Entries never written read as -9900, time 0,
// stale, through per-entry written flags cleared by reset (no clearing pass).
// A stalled result holds the query in the parse/read stage; the input register
// then takes one more beat and item_stall stays high until the result is taken.
module telemetry_line_parser_router
    import tlpr_pkg::*;
#(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES,
    parameter int MAX_LINE      = DEF_MAX_LINE
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         rx_byte,
    input  wire logic [3:0]         query_address,
    input  wire logic [1:0]         quantity,
    input  wire logic [31:0]        age_limit_ms,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      reading,
    output logic [31:0]             stamp_ms,
    output logic                    stale,
    output logic                    address_ok
);

    localparam int ENTRIES = 4 * NUM_ADDRESSES;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LEN_W   = $clog2(MAX_LINE + 1);

    // input stage
    logic              a_valid_reg;
    logic [1:0]        a_action_reg;
    logic [7:0]        a_byte_reg;
    logic [3:0]        a_addr_reg;
    logic [1:0]        a_qty_reg;
    logic [31:0]       a_max_age_reg;

    // parse state
    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [3:0]        line_addr_reg, line_addr_next;
    logic              addressed_reg, addressed_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic              neg_reg, neg_next;
    logic [31:0]       acc_reg, acc_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [31:0]       now_reg;
    logic [ENTRIES-1:0] written_reg;

    // second stage
    logic              b_valid_reg;
    logic              b_query_reg;
    logic              b_wr_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [31:0]       b_acc_reg;
    logic [FC_W-1:0]   b_shift_reg;
    logic              b_neg_reg;
    logic [31:0]       b_stamp_reg;
    logic              b_ok_reg;
    logic [31:0]       b_max_age_reg;
    logic [31:0]       b_now_reg;
    logic              b_written_reg;
    logic              b_hit_reg;
    logic [63:0]       b_hit_data_reg;

    // result register
    logic              out_valid_reg;
    logic signed [31:0] out_reading_reg;
    logic [31:0]       out_stamp_reg;
    logic              out_stale_reg;
    logic              out_ok_reg;

    logic              out_free, b_leave, b_free, a_move, accept;
    logic              byte_move, a_query, a_tick;
    logic [7:0]        c;
    logic              is_lf, is_cr, is_digit, is_blank, is_sign, is_dot;
    logic [LEN_W-1:0]  len_plus;
    logic              overlong;
    logic [31:0]       mac;
    logic              line_short, line_addr_bad, eol_wr;
    qty_dec_t          qd;
    logic [IDX_W-1:0]  line_idx, rd_idx;
    logic              q_ok;
    logic              hit;
    logic [45:0]       prod;
    logic [31:0]       mag;
    logic signed [31:0] wr_value;
    logic [63:0]       wr_data, rd_data, sel_data;
    logic [31:0]       age;
    logic signed [31:0] res_reading;
    logic [31:0]       res_stamp;
    logic              res_stale;

    // ---------------- handshake ----------------
    assign out_free   = !out_valid_reg || !result_stall;
    assign b_leave    = !b_query_reg || out_free;
    assign b_free     = !b_valid_reg || b_leave;
    assign a_move     = a_valid_reg && b_free;
    assign item_stall = a_valid_reg && !b_free;
    assign accept     = item_valid && !item_stall;

    assign byte_move = a_move && (a_action_reg == ACT_BYTE);
    assign a_tick    = a_move && (a_action_reg == ACT_TICK);
    assign a_query   = a_action_reg == ACT_QUERY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_action_reg  <= action;
            a_byte_reg    <= rx_byte;
            a_addr_reg    <= query_address;
            a_qty_reg     <= quantity;
            a_max_age_reg <= age_limit_ms;
        end
    end

    // ---------------- byte classification ----------------
    assign c        = a_byte_reg;
    assign is_lf    = c == CH_LF;
    assign is_cr    = c == CH_CR;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_dot   = c == CH_DOT;
    assign len_plus = len_reg + LEN_W'(1);
    assign overlong = !is_lf && !is_cr && (len_plus >= LEN_W'(MAX_LINE));
    assign mac      = sat_mac(acc_reg, c[3:0]);

    // ---------------- parse state machine: next phase ----------------
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_move)
        begin
            if (is_lf || overlong)
            begin
                phase_next = PH_START;
            end
            else if (!is_cr)
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        phase_next = is_digit ? PH_CMD : PH_BLANK;
                    end
                    PH_CMD:
                    begin
                        phase_next = PH_BLANK;
                    end
                    PH_BLANK:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_BLANK;
                        end
                        else if (is_sign || is_digit)
                        begin
                            phase_next = PH_INT;
                        end
                        else if (is_dot)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_INT;
                        end
                        else if (is_dot)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_FRAC:
                    begin
                        phase_next = is_digit ? PH_FRAC : PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // ---------------- parse state machine: line datapath ----------------
    always_comb
    begin
        len_next       = len_reg;
        line_addr_next = line_addr_reg;
        addressed_next = addressed_reg;
        cmd_next       = cmd_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        fc_next        = fc_reg;
        if (byte_move)
        begin
            if (is_lf || overlong)
            begin
                len_next       = '0;
                line_addr_next = 4'd0;
                addressed_next = 1'b0;
                cmd_next       = 8'd0;
                neg_next       = 1'b0;
                acc_next       = 32'd0;
                fc_next        = '0;
            end
            else if (!is_cr)
            begin
                len_next = len_plus;
                case (phase_reg)
                    PH_START:
                    begin
                        if (is_digit)
                        begin
                            line_addr_next = c[3:0];
                            addressed_next = 1'b1;
                        end
                        else
                        begin
                            cmd_next = c;
                        end
                    end
                    PH_CMD:
                    begin
                        cmd_next = c;
                    end
                    PH_BLANK:
                    begin
                        if (!is_blank && is_sign)
                        begin
                            neg_next = c == CH_MINUS;
                        end
                        else if (!is_blank && is_digit)
                        begin
                            acc_next = mac;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit)
                        begin
                            acc_next = mac;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit && (fc_reg < FC_W'(FRAC_DIGITS)))
                        begin
                            acc_next = mac;
                            fc_next  = fc_reg + FC_W'(1);
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            len_reg       <= '0;
            line_addr_reg <= 4'd0;
            addressed_reg <= 1'b0;
            cmd_reg       <= 8'd0;
            neg_reg       <= 1'b0;
            acc_reg       <= 32'd0;
            fc_reg        <= '0;
            now_reg       <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            line_addr_reg <= line_addr_next;
            addressed_reg <= addressed_next;
            cmd_reg       <= cmd_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            fc_reg        <= fc_next;
            if (a_tick)
            begin
                now_reg <= now_reg + 32'd1;
            end
        end
    end

    // ---------------- end of line ----------------
    assign line_short    = (len_reg < LEN_W'(2)) || (addressed_reg && (len_reg < LEN_W'(3)));
    assign line_addr_bad = line_addr_reg >= 4'(NUM_ADDRESSES);
    assign qd            = quantity_of(cmd_reg);
    assign eol_wr        = !line_short && !line_addr_bad && qd.ok;
    assign line_idx      = IDX_W'(qd.qty) * IDX_W'(NUM_ADDRESSES) + IDX_W'(line_addr_reg);

    // ---------------- query read ----------------
    assign q_ok   = a_addr_reg < 4'(NUM_ADDRESSES);
    assign rd_idx = IDX_W'(a_qty_reg) * IDX_W'(NUM_ADDRESSES)
                  + (q_ok ? IDX_W'(a_addr_reg) : IDX_W'(0));
    assign hit    = b_valid_reg && b_wr_reg && (b_idx_reg == rd_idx);

    // ---------------- second stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_query_reg <= 1'b0;
            b_wr_reg    <= 1'b0;
        end
        else if (a_move)
        begin
            b_valid_reg <= a_query || (byte_move && is_lf && eol_wr);
            b_query_reg <= a_query;
            b_wr_reg    <= byte_move && is_lf && eol_wr;
        end
        else if (b_leave)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_idx_reg      <= a_query ? rd_idx : line_idx;
            b_acc_reg      <= acc_reg;
            b_shift_reg    <= FC_W'(FRAC_DIGITS) - fc_reg;
            b_neg_reg      <= neg_reg;
            b_stamp_reg    <= now_reg;
            b_ok_reg       <= q_ok;
            b_max_age_reg  <= a_max_age_reg;
            b_now_reg      <= now_reg;
            b_written_reg  <= written_reg[rd_idx] || hit;
            b_hit_reg      <= hit;
            b_hit_data_reg <= wr_data;
        end
    end

    // value scaling for a line write
    assign prod     = 46'(b_acc_reg) * 46'(pow_ten(b_shift_reg));
    assign mag      = (prod > 46'(MAG_LIMIT)) ? MAG_LIMIT : prod[31:0];
    assign wr_value = b_neg_reg ? -$signed(mag) : $signed(mag);
    assign wr_data  = {b_stamp_reg, wr_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (b_valid_reg && b_wr_reg)
        begin
            written_reg[b_idx_reg] <= 1'b1;
        end
    end

    tlpr_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (b_valid_reg && b_wr_reg),
        .wr_addr (b_idx_reg),
        .wr_data (wr_data),
        .rd_en   (a_move && a_query),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    // ---------------- query result ----------------
    assign sel_data = b_hit_reg ? b_hit_data_reg : rd_data;
    assign age      = b_now_reg - sel_data[63:32];

    always_comb
    begin
        res_reading = NO_VALUE;
        res_stamp   = 32'd0;
        res_stale   = 1'b1;
        if (b_ok_reg && b_written_reg)
        begin
            res_reading = $signed(sel_data[31:0]);
            res_stamp   = sel_data[63:32];
            res_stale   = age > b_max_age_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= b_valid_reg && b_query_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && b_valid_reg && b_query_reg)
        begin
            out_reading_reg <= res_reading;
            out_stamp_reg   <= res_stamp;
            out_stale_reg   <= res_stale;
            out_ok_reg      <= b_ok_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign reading      = out_reading_reg;
    assign stamp_ms     = out_stamp_reg;
    assign stale        = out_stale_reg;
    assign address_ok   = out_ok_reg;

endmodule
`default_nettype wire

@@ bench/tlpr_reading_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpr_reading_checker
// Watches both channels of the telemetry line parser/router. It keeps its own
// copy of the line parser and the value/time store, queues the reading that
// each accepted query should return, and compares every accepted result beat
// field by field against the oldest queued reading.
// ----------------------------------------------------------------------------
module tlpr_reading_checker
    import tlpr_pkg::*;
#(
    parameter int NUM_ADDRESSES = DEF_NUM_ADDRESSES,
    parameter int MAX_LINE      = DEF_MAX_LINE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [1:0]         action,
    input  logic [7:0]         rx_byte,
    input  logic [3:0]         query_address,
    input  logic [1:0]         quantity,
    input  logic [31:0]        age_limit_ms,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic signed [31:0] reading,
    input  logic [31:0]        stamp_ms,
    input  logic               stale,
    input  logic               address_ok,
    output int                 mismatches,
    output int                 readings_due
);

    localparam int ENTRY_COUNT = 4 * NUM_ADDRESSES;

    typedef struct packed {
        logic signed [31:0] reading;
        logic [31:0]        stamp;
        logic               stale;
        logic               ok;
    } stored_reading_t;

    stored_reading_t    pending_readings[$];

    logic signed [31:0] value_mem   [ENTRY_COUNT];
    logic [31:0]        stamp_mem   [ENTRY_COUNT];
    logic               written_mem [ENTRY_COUNT];
    logic [31:0]        clock_ms;

    int                 line_len;
    phase_t             phase;
    logic [3:0]         line_addr;
    logic               has_addr;
    logic [7:0]         cmd_char;
    logic               negative;
    logic [31:0]        accum;
    int                 frac_cnt;

    task automatic clear_line();
        line_len  = 0;
        phase     = PH_START;
        line_addr = '0;
        has_addr  = 1'b0;
        cmd_char  = '0;
        negative  = 1'b0;
        accum     = '0;
        frac_cnt  = 0;
    endtask

    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
        logic [63:0] sum;
        sum = {32'd0, acc} * 64'd10 + {60'd0, c[3:0]};
        return (sum > {32'd0, MAG_LIMIT}) ? MAG_LIMIT : sum[31:0];
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [63:0]     mag;
        logic [1:0]      qsel;
        logic            qvalid;
        logic            is_digit;
        logic            is_blank;
        int              idx;
        stored_reading_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                value_mem[i]   = NO_VALUE;
                stamp_mem[i]   = '0;
                written_mem[i] = 1'b0;
            end
            clock_ms = '0;
            clear_line();
            pending_readings.delete();
            mismatches   = 0;
            readings_due = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: result beat with no query pending, expected none, actual %0h",
                             $time, reading);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("reading", want.reading, reading);
                    check_field("stamp_ms", want.stamp, stamp_ms);
                    check_field("stale", {31'd0, want.stale}, {31'd0, stale});
                    check_field("address_ok", {31'd0, want.ok}, {31'd0, address_ok});
                end
            end
            if (item_valid && !item_stall) begin
                case (action)
                    ACT_BYTE:
                    begin
                        is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
                        is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                                   (rx_byte == CH_VT) || (rx_byte == CH_FF);
                        if (rx_byte == CH_LF) begin
                            qvalid = 1'b1;
                            qsel   = 2'd0;
                            case (cmd_char)
                                "I", "i": qsel = 2'd0;
                                "R", "r": qsel = 2'd1;
                                "F", "f": qsel = 2'd2;
                                "P", "p": qsel = 2'd3;
                                default:  qvalid = 1'b0;
                            endcase
                            if (line_len >= 2 && !(has_addr && line_len < 3) &&
                                line_addr < NUM_ADDRESSES && qvalid)
                            begin
                                mag = {32'd0, accum};
                                for (int k = frac_cnt; k < FRAC_DIGITS; k++) begin
                                    mag = mag * 64'd10;
                                end
                                if (mag > {32'd0, MAG_LIMIT}) begin
                                    mag = {32'd0, MAG_LIMIT};
                                end
                                idx = int'(qsel) * NUM_ADDRESSES + int'(line_addr);
                                value_mem[idx]   = negative ? -mag[31:0] : mag[31:0];
                                stamp_mem[idx]   = clock_ms;
                                written_mem[idx] = 1'b1;
                            end
                            clear_line();
                        end else if (rx_byte != CH_CR) begin
                            line_len++;
                            case (phase)
                                PH_START:
                                begin
                                    if (is_digit) begin
                                        line_addr = rx_byte[3:0];
                                        has_addr  = 1'b1;
                                        phase     = PH_CMD;
                                    end else begin
                                        cmd_char = rx_byte;
                                        phase    = PH_BLANK;
                                    end
                                end
                                PH_CMD:
                                begin
                                    cmd_char = rx_byte;
                                    phase    = PH_BLANK;
                                end
                                PH_BLANK:
                                begin
                                    if (!is_blank) begin
                                        if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                                            negative = (rx_byte == CH_MINUS);
                                            phase    = PH_INT;
                                        end else if (is_digit) begin
                                            accum = add_digit(accum, rx_byte);
                                            phase = PH_INT;
                                        end else if (rx_byte == CH_DOT) begin
                                            phase = PH_FRAC;
                                        end else begin
                                            phase = PH_DONE;
                                        end
                                    end
                                end
                                PH_INT:
                                begin
                                    if (is_digit) begin
                                        accum = add_digit(accum, rx_byte);
                                    end else if (rx_byte == CH_DOT) begin
                                        phase = PH_FRAC;
                                    end else begin
                                        phase = PH_DONE;
                                    end
                                end
                                PH_FRAC:
                                begin
                                    if (is_digit) begin
                                        if (frac_cnt < FRAC_DIGITS) begin
                                            accum = add_digit(accum, rx_byte);
                                            frac_cnt++;
                                        end
                                    end else begin
                                        phase = PH_DONE;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            if (line_len >= MAX_LINE) begin
                                clear_line();
                            end
                        end
                    end
                    ACT_TICK:
                    begin
                        clock_ms = clock_ms + 32'd1;
                    end
                    ACT_QUERY:
                    begin
                        want.ok      = (query_address < NUM_ADDRESSES);
                        want.reading = NO_VALUE;
                        want.stamp   = '0;
                        want.stale   = 1'b1;
                        if (want.ok) begin
                            idx = int'(quantity) * NUM_ADDRESSES + int'(query_address);
                            want.reading = value_mem[idx];
                            want.stamp   = stamp_mem[idx];
                            want.stale   = !written_mem[idx] ||
                                           ((clock_ms - stamp_mem[idx]) > age_limit_ms);
                        end
                        pending_readings.push_back(want);
                    end
                    default:
                    begin
                    end
                endcase
            end
            readings_due = pending_readings.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the telemetry line parser/router. A short directed
// run covers the parsing corner cases and query outcomes, then randomized
// lines, noise, ticks and queries follow with random idle bursts on both
// channels. Checking is done by the reading checker next to the block.
// ----------------------------------------------------------------------------
module tb_top;
    import tlpr_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 950;
    localparam int         CALM_AFTER   = 850;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 10;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         action;
    logic [7:0]         rx_byte;
    logic [3:0]         query_address;
    logic [1:0]         quantity;
    logic [31:0]        age_limit_ms;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] reading;
    logic [31:0]        stamp_ms;
    logic               stale;
    logic               address_ok;

    int                 mismatches;
    int                 readings_due;
    int                 cycle_count = 0;
    int                 beats_sent  = 0;
    int                 idle_level  = 1;
    bit                 calm        = 1'b0;
    string              cmd_chars   = "IRFPirfp";

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    telemetry_line_parser_router u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .query_address (query_address),
        .quantity      (quantity),
        .age_limit_ms  (age_limit_ms),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .reading       (reading),
        .stamp_ms      (stamp_ms),
        .stale         (stale),
        .address_ok    (address_ok)
    );

    tlpr_reading_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .query_address (query_address),
        .quantity      (quantity),
        .age_limit_ms  (age_limit_ms),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .reading       (reading),
        .stamp_ms      (stamp_ms),
        .stale         (stale),
        .address_ok    (address_ok),
        .mismatches    (mismatches),
        .readings_due  (readings_due)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        result_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (!calm && idle_level != 0 &&
                $urandom_range(0, idle_level == 1 ? 7 : 2) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // one beat on the item channel; returns at the edge where it is taken
    task automatic send_beat(input logic [1:0] act, input logic [7:0] b,
                             input logic [3:0] qa, input logic [1:0] q,
                             input logic [31:0] age);
        bit taken;
        if (!calm && idle_level != 0 && $urandom_range(0, idle_level == 1 ? 7 : 2) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        action        <= act;
        rx_byte       <= b;
        query_address <= qa;
        quantity      <= q;
        age_limit_ms  <= age;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        if (act != ACT_UNUSED) begin
            beats_sent++;
        end
        if (beats_sent % 64 == 0) begin
            idle_level = $urandom_range(0, 2);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(ACT_BYTE, b, 4'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_query(input logic [3:0] qa, input logic [1:0] q,
                              input logic [31:0] age);
        send_beat(ACT_QUERY, 8'($urandom), qa, q, age);
    endtask

    task automatic send_tick();
        send_beat(ACT_TICK, 8'($urandom), 4'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic send_random_line();
        int n;
        if ($urandom_range(0, 3) != 0) begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) != 0) begin
            send_byte(cmd_chars[$urandom_range(0, 7)]);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0:       send_byte(CH_SPACE);
                1:       send_byte(CH_TAB);
                2:       send_byte(CH_VT);
                default: send_byte(CH_FF);
            endcase
        end
        case ($urandom_range(0, 2))
            0:       send_byte(CH_PLUS);
            1:       send_byte(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 0) begin
            send_byte(CH_DOT);
            repeat ($urandom_range(0, 5)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_byte(CH_CR);
        end
        send_byte(CH_LF);
    endtask

    function automatic logic [31:0] pick_age();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 30));
        endcase
    endfunction

    initial begin
        int start;
        int r;
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        action        <= ACT_BYTE;
        rx_byte       <= '0;
        query_address <= '0;
        quantity      <= '0;
        age_limit_ms  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, bad address, unused action
        send_query(4'd0, 2'd0, 32'hFFFF_FFFF);
        send_query(4'd15, 2'd3, 32'd0);
        send_beat(ACT_UNUSED, 8'hFF, 4'hF, 2'd3, 32'hFFFF_FFFF);
        // saturation, extra fraction digits, CR
        send_text("9p-99999999999.99999");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_query(4'd9, 2'd3, 32'd0);
        send_text("0I+2.5");
        send_byte(CH_LF);
        send_tick();
        send_query(4'd0, 2'd0, 32'd0);
        send_query(4'd0, 2'd0, 32'd1);
        send_text("r.125");
        send_byte(CH_LF);
        send_query(4'd0, 2'd1, 32'hFFFF_FFFF);
        // short lines, unknown command, blank before number
        send_text("I");
        send_byte(CH_LF);
        send_text("5F");
        send_byte(CH_LF);
        send_text("3x12");
        send_byte(CH_LF);
        send_text("f\t 7");
        send_byte(CH_LF);
        send_query(4'd5, 2'd2, 32'hFFFF_FFFF);
        send_query(4'd3, 2'd0, 32'hFFFF_FFFF);
        send_query(4'd0, 2'd2, 32'd5);
        // overlong line is cleared
        send_text("4P");
        repeat (DEF_MAX_LINE) send_byte("1");
        send_byte(CH_LF);
        send_query(4'd4, 2'd3, 32'hFFFF_FFFF);

        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            calm = (beats_sent - start > CALM_AFTER);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_random_line();
            end else if (r < 53) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(CH_LF);
                end
            end else if (r < 55) begin
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(DEF_MAX_LINE - 4, DEF_MAX_LINE + 8)) begin
                    send_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
                send_byte(CH_LF);
            end else if (r < 73) begin
                repeat ($urandom_range(1, 4)) send_tick();
            end else if (r < 97) begin
                send_query(($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 9)) :
                           4'($urandom_range(10, 15)), 2'($urandom), pick_age());
            end else begin
                send_beat(ACT_UNUSED, 8'($urandom), 4'($urandom), 2'($urandom), $urandom);
            end
        end
        item_valid <= 1'b0;

        do @(negedge clk); while (readings_due != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && readings_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
